### hw/rtl/pnc_pkg.sv
package pnc_pkg;

   localparam int PLACES    = 18;
   localparam int SHUTTLES  = 2;
   localparam int TOKEN_W   = 2;
   localparam int REQ_W     = 16;
   localparam int RSP_W     = 16;

   typedef logic [TOKEN_W-1:0] token_type;
   typedef logic [PLACES:1][TOKEN_W-1:0] marking_type;

   // One sensor scan, first field in the highest bits.
   typedef struct packed {
      logic [1:0] pin_sensors;
      logic [1:0] switch_left_pos;
      logic [1:0] switch_right_pos;
      logic [5:0] stop_sensors;
   } scan_type;

   // Actuator word, first field in the highest bits.
   typedef struct packed {
      logic [6:0] stop_gates;
      logic [1:0] go_left;
      logic [1:0] go_right;
      logic [1:0] switch_lock;
      logic [1:0] switch_drive;
   } act_type;

   localparam int SCAN_W = $bits(scan_type);
   localparam int ACT_W  = $bits(act_type);

   localparam token_type TOKEN_MAX = {TOKEN_W{1'b1}};

   function automatic token_type tok_take(token_type v);
      tok_take = (v != '0) ? v - token_type'(1) : v;
   endfunction

   function automatic token_type tok_give(token_type v);
      tok_give = (v != TOKEN_MAX) ? v + token_type'(1) : v;
   endfunction

   function automatic marking_type reset_marking();
      marking_type m;
      m = '0;
      m[15] = token_type'(1);
      m[16] = token_type'(1);
      m[17] = token_type'(SHUTTLES);
      reset_marking = m;
   endfunction

endpackage

### hw/rtl/pnc_step.sv
module pnc_step (
   input  pnc_pkg::marking_type marking_in,
   input  pnc_pkg::scan_type    scan,
   output pnc_pkg::marking_type marking_out,
   output pnc_pkg::act_type     act
);

   pnc_pkg::marking_type m;
   logic ps1, ps2, ps4, ps5, ps6, ps20;
   logic r1, r2, l1, l2, pin1, pin2;

   assign ps1  = scan.stop_sensors[0];
   assign ps2  = scan.stop_sensors[1];
   assign ps4  = scan.stop_sensors[2];
   assign ps5  = scan.stop_sensors[3];
   assign ps6  = scan.stop_sensors[4];
   assign ps20 = scan.stop_sensors[5];
   assign r1   = scan.switch_right_pos[0];
   assign r2   = scan.switch_right_pos[1];
   assign l1   = scan.switch_left_pos[0];
   assign l2   = scan.switch_left_pos[1];
   assign pin1 = scan.pin_sensors[0];
   assign pin2 = scan.pin_sensors[1];

   // Fire transitions in net order; each sees the marking left by the ones before.
   always_comb begin
      m = marking_in;
      if ((|m[17]) && (|m[16]) && ps1) begin
         m[17] = pnc_pkg::tok_take(m[17]);
         m[16] = pnc_pkg::tok_take(m[16]);
         m[1]  = pnc_pkg::tok_give(m[1]);
      end
      if ((|m[1]) && r1) begin
         m[1] = pnc_pkg::tok_take(m[1]);
         m[2] = pnc_pkg::tok_give(m[2]);
      end else if ((|m[1]) && l1) begin
         m[1] = pnc_pkg::tok_take(m[1]);
         m[3] = pnc_pkg::tok_give(m[3]);
      end
      if ((|m[2]) && l1 && !pin2) begin
         m[2] = pnc_pkg::tok_take(m[2]);
         m[4] = pnc_pkg::tok_give(m[4]);
      end
      if ((|m[3]) && r1 && !pin1) begin
         m[3] = pnc_pkg::tok_take(m[3]);
         m[5] = pnc_pkg::tok_give(m[5]);
      end
      if ((|m[4]) && !ps1) begin
         m[4] = pnc_pkg::tok_take(m[4]);
         m[6] = pnc_pkg::tok_give(m[6]);
      end
      if ((|m[5]) && !ps1) begin
         m[5] = pnc_pkg::tok_take(m[5]);
         m[7] = pnc_pkg::tok_give(m[7]);
      end
      if ((|m[6]) && ps4) begin
         m[6]  = pnc_pkg::tok_take(m[6]);
         m[18] = pnc_pkg::tok_give(m[18]);
         m[16] = pnc_pkg::tok_give(m[16]);
      end
      if ((|m[7]) && ps2) begin
         m[7]  = pnc_pkg::tok_take(m[7]);
         m[8]  = pnc_pkg::tok_give(m[8]);
         m[16] = pnc_pkg::tok_give(m[16]);
      end
      if ((|m[8]) && (|m[15]) && ps5) begin
         m[8]  = pnc_pkg::tok_take(m[8]);
         m[15] = pnc_pkg::tok_take(m[15]);
         m[10] = pnc_pkg::tok_give(m[10]);
      end
      if ((|m[18]) && (|m[15])) begin
         m[18] = pnc_pkg::tok_take(m[18]);
         m[15] = pnc_pkg::tok_take(m[15]);
         m[9]  = pnc_pkg::tok_give(m[9]);
      end
      if ((|m[9]) && l2 && !ps6) begin
         m[9]  = pnc_pkg::tok_take(m[9]);
         m[11] = pnc_pkg::tok_give(m[11]);
      end
      if ((|m[10]) && r2 && !ps6) begin
         m[10] = pnc_pkg::tok_take(m[10]);
         m[12] = pnc_pkg::tok_give(m[12]);
      end
      if ((|m[11]) && !ps4) begin
         m[11] = pnc_pkg::tok_take(m[11]);
         m[13] = pnc_pkg::tok_give(m[13]);
      end
      if ((|m[12]) && !ps5) begin
         m[12] = pnc_pkg::tok_take(m[12]);
         m[13] = pnc_pkg::tok_give(m[13]);
      end
      if ((|m[13]) && ps20) begin
         m[13] = pnc_pkg::tok_take(m[13]);
         m[14] = pnc_pkg::tok_give(m[14]);
      end
      if ((|m[14]) && !ps20) begin
         m[14] = pnc_pkg::tok_take(m[14]);
         m[17] = pnc_pkg::tok_give(m[17]);
         m[15] = pnc_pkg::tok_give(m[15]);
      end
   end

   assign marking_out = m;

   assign act.switch_drive = {(|m[9]) | (|m[10]), (|m[2]) | (|m[3])};
   assign act.switch_lock  = {(|m[11]) | (|m[12]), (|m[4]) | (|m[5])};
   assign act.go_right     = {|m[10], |m[3]};
   assign act.go_left      = {|m[9], |m[2]};
   assign act.stop_gates   = {|m[17], |m[14], |m[12], |m[11], |m[8], |m[8],
                              (|m[4]) | (|m[5])};

endmodule

### hw/rtl/petri_net_conveyor_controller_unit.sv
// Petri-net controller for two shuttle-switching stations of a conveyor line.
// The req_ channel carries one sensor scan per item; the rsp_ channel returns
// exactly one actuator word per scan, in order. The marking of the net lives
// in this block and advances once per scan.
// A scan is taken into the scan register and its actuator word into the
// result register, with rsp_tvalid high. Throughput: one scan per cycle
// while rsp_tready is high. The transition chain is a single combinational
// pass between them; the marking register closes the loop in that same cycle.
// Reset (synchronous, active high) empties both registers and loads the
// initial marking: one token in p15 and p16, two shuttles in p17.
// When rsp_tready is low the result is held, the scan register keeps or takes
// one scan, and req_tready then drops until the result is taken. A result being taken in the
// same cycle frees the pipeline for a new scan at once.
module petri_net_conveyor_controller_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // [5:0] stop_sensors, [7:6] switch_right_pos, [9:8] switch_left_pos,
   // [11:10] pin_sensors, [15:12] zero
   input  logic [pnc_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [1:0] switch_drive, [3:2] switch_lock, [5:4] go_right, [7:6] go_left,
   // [14:8] stop_gates, [15] zero
   output logic [pnc_pkg::RSP_W-1:0] rsp_tdata
);

   logic                 scan_valid_ff, scan_valid_in;
   pnc_pkg::scan_type    scan_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   pnc_pkg::act_type     act_ff;
   pnc_pkg::marking_type marking_ff, marking_in;
   pnc_pkg::act_type     act_in;
   logic                 advance;
   logic                 req_take;

   assign advance    = scan_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !scan_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign scan_valid_in = req_take || (scan_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && !rsp_tready);

   pnc_step u_step (
      .marking_in  (marking_ff),
      .scan        (scan_ff),
      .marking_out (marking_in),
      .act         (act_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         marking_ff    <= pnc_pkg::reset_marking();
      end else begin
         scan_valid_ff <= scan_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (advance) begin
            marking_ff <= marking_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         scan_ff <= pnc_pkg::scan_type'(req_tdata[pnc_pkg::SCAN_W-1:0]);
      end
      if (advance) begin
         act_ff <= act_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(pnc_pkg::RSP_W - pnc_pkg::ACT_W){1'b0}}, act_ff};

endmodule
